// ----- src/fece_pkg.sv -----
// Shared types and constants for the fire effect cell engine.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package fece_pkg;

    // Frame geometry; the store holds one spare byte past the last cell
    localparam int unsigned GRID_COLS   = 640;
    localparam int unsigned GRID_ROWS   = 240;
    localparam int unsigned STORE_DEPTH = GRID_COLS * GRID_ROWS + 1;

    // Field widths fixed by the stream format
    localparam int unsigned ADDR_W = 18;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned COL_W  = 10;
    localparam int unsigned ROW_W  = 8;

    // Pixel arithmetic constants
    localparam logic [PIX_W-1:0] CLAMP_MAX   = 8'd124;
    localparam logic [PIX_W-1:0] STEP        = 8'd4;
    localparam logic [PIX_W-1:0] JITTER_HIGH = 8'd252;
    localparam logic [PIX_W-1:0] JITTER_LOW  = 8'd4;
    localparam logic [1:0]       JITTER_NONE = 2'd3;

    // Action codes on the input stream
    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_CLEAR  = 3'd1;
    localparam logic [2:0] ACT_SEED   = 3'd2;
    localparam logic [2:0] ACT_PROP   = 3'd3;
    localparam logic [2:0] ACT_JITTER = 3'd4;

    // Command queue depth between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Classified operation; KIND_NOP answers all zeros
    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_READ,
        KIND_CLEAR,
        KIND_SEED,
        KIND_PROP,
        KIND_JITTER
    } kind_t;

    // One classified command as it travels through the queue
    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic              row_zero;
        logic [1:0]        offs;
        logic              decay;
        logic [5:0]        seed;
        logic [1:0]        jit;
    } cmd_t;

endpackage

// ----- src/fece_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fece_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/fece_front.sv -----
// Front end: accepts input words, checks ranges and forms the cell address.
// Depends on fece_pkg.
module fece_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [2:0]                action,
    input  logic [fece_pkg::COL_W-1:0] col,
    input  logic [fece_pkg::ROW_W-1:0] row,
    input  logic [1:0]                offset_rand,
    input  logic                      decay_rand,
    input  logic [5:0]                seed_rand,
    input  logic [1:0]                jitter_rand,
    input  logic                      q_full,
    output logic                      q_push,
    output fece_pkg::cmd_t            q_cmd
);

    logic                           col_ok;
    logic                           row_ok;
    logic                           use_bottom;
    logic [fece_pkg::ROW_W-1:0]     row_sel;
    fece_pkg::kind_t                kind;

    assign col_ok = col < fece_pkg::COL_W'(fece_pkg::GRID_COLS);
    assign row_ok = row < fece_pkg::ROW_W'(fece_pkg::GRID_ROWS);

    always_comb
    begin
        kind       = fece_pkg::KIND_NOP;
        use_bottom = 1'b0;
        unique case (action)
            fece_pkg::ACT_READ:   kind = fece_pkg::KIND_READ;
            fece_pkg::ACT_CLEAR:  kind = fece_pkg::KIND_CLEAR;
            fece_pkg::ACT_SEED:
            begin
                kind       = fece_pkg::KIND_SEED;
                use_bottom = 1'b1;
            end
            fece_pkg::ACT_PROP:   kind = fece_pkg::KIND_PROP;
            fece_pkg::ACT_JITTER:
            begin
                kind       = fece_pkg::KIND_JITTER;
                use_bottom = 1'b1;
            end
            default:              kind = fece_pkg::KIND_NOP;
        endcase
        // drop bad columns, and bad rows where the row is used
        if (!col_ok || (!use_bottom && !row_ok))
        begin
            kind = fece_pkg::KIND_NOP;
        end
    end

    assign row_sel = use_bottom ? fece_pkg::ROW_W'(fece_pkg::GRID_ROWS - 1) : row;

    always_comb
    begin
        q_cmd          = '0;
        q_cmd.kind     = kind;
        q_cmd.addr     = fece_pkg::ADDR_W'(row_sel) * fece_pkg::ADDR_W'(fece_pkg::GRID_COLS)
                       + fece_pkg::ADDR_W'(col);
        q_cmd.row_zero = (row == '0);
        q_cmd.offs     = offset_rand;
        q_cmd.decay    = decay_rand;
        q_cmd.seed     = seed_rand;
        q_cmd.jit      = jitter_rand;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ----- src/fece_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on fece_pkg.
module fece_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fece_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output fece_pkg::cmd_t head_cmd
);

    localparam int unsigned PTR_W = $clog2(fece_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    fece_pkg::cmd_t   entry_reg [fece_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(fece_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/fece_back.sv -----
// Back end: read-modify-write of the frame store and the output register.
// Depends on fece_pkg and fece_ram.
module fece_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  fece_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fece_pkg::PIX_W-1:0]  pixel_value,
    output logic                        wrote,
    output logic [fece_pkg::ADDR_W-1:0] write_address
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

    state_t                      state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;
    fece_pkg::cmd_t              cur_reg, cur_next;
    logic [fece_pkg::PIX_W-1:0]  pix_reg, pix_next;
    logic [fece_pkg::ADDR_W-1:0] tgt_reg, tgt_next;
    logic                        tgt_zero_reg, tgt_zero_next;
    logic [fece_pkg::PIX_W-1:0]  out_pix_reg, out_pix_next;
    logic                        out_wrote_reg, out_wrote_next;
    logic [fece_pkg::ADDR_W-1:0] out_addr_reg, out_addr_next;

    logic                        rd_en;
    logic [fece_pkg::PIX_W-1:0]  rd_data;
    logic                        wr_en;
    logic [fece_pkg::ADDR_W-1:0] wr_addr;
    logic [fece_pkg::PIX_W-1:0]  wr_data;

    logic [fece_pkg::ADDR_W-1:0] tgt_plus1;
    logic [fece_pkg::PIX_W-1:0]  clamped;
    logic [fece_pkg::PIX_W-1:0]  prop_val;
    logic [fece_pkg::PIX_W-1:0]  jit_val;
    logic                        jit_ok;
    logic                        slot_free;

    fece_ram #(
        .DATA_W (fece_pkg::PIX_W),
        .DEPTH  (fece_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cmd.addr),
        .rd_data (rd_data)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign rd_en     = (state_reg == S_IDLE) && cmd_valid;
    assign cmd_pop   = rd_en;

    // target + 1 of a propagate; only meaningful for rows above zero
    assign tgt_plus1 = cur_reg.addr + fece_pkg::ADDR_W'(cur_reg.offs)
                     - fece_pkg::ADDR_W'(fece_pkg::GRID_COLS);

    assign clamped  = (pix_reg > fece_pkg::CLAMP_MAX) ? fece_pkg::CLAMP_MAX : pix_reg;
    assign prop_val = clamped - (cur_reg.decay ? fece_pkg::STEP : '0);
    assign jit_ok   = (cur_reg.jit != fece_pkg::JITTER_NONE)
                   && (pix_reg < fece_pkg::JITTER_HIGH) && (pix_reg > fece_pkg::JITTER_LOW);
    assign jit_val  = pix_reg + {4'b0, cur_reg.jit, 2'b00} - fece_pkg::STEP;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cur_next       = cur_reg;
        pix_next       = pix_reg;
        tgt_next       = tgt_reg;
        tgt_zero_next  = tgt_zero_reg;
        out_pix_next   = out_pix_reg;
        out_wrote_next = out_wrote_reg;
        out_addr_next  = out_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg.addr;
        wr_data        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next   = cmd;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                pix_next      = rd_data;
                tgt_zero_next = (tgt_plus1 == '0);
                tgt_next      = tgt_plus1 - 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = '0;
                    out_wrote_next = 1'b0;
                    out_addr_next  = cur_reg.addr;
                    unique case (cur_reg.kind)
                        fece_pkg::KIND_READ:
                        begin
                            out_pix_next = pix_reg;
                        end
                        fece_pkg::KIND_CLEAR:
                        begin
                            wr_en          = 1'b1;
                            out_wrote_next = 1'b1;
                        end
                        fece_pkg::KIND_SEED:
                        begin
                            wr_en          = 1'b1;
                            wr_data        = {cur_reg.seed, 2'b00};
                            out_pix_next   = {cur_reg.seed, 2'b00};
                            out_wrote_next = 1'b1;
                        end
                        fece_pkg::KIND_PROP:
                        begin
                            out_pix_next = clamped;
                            // drop row zero, a cold cell or a target before the store
                            if (!cur_reg.row_zero && clamped != '0 && !tgt_zero_reg)
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = tgt_reg;
                                wr_data        = prop_val;
                                out_pix_next   = prop_val;
                                out_wrote_next = 1'b1;
                                out_addr_next  = tgt_reg;
                            end
                        end
                        fece_pkg::KIND_JITTER:
                        begin
                            out_pix_next = pix_reg;
                            if (jit_ok)
                            begin
                                wr_en          = 1'b1;
                                wr_data        = jit_val;
                                out_pix_next   = jit_val;
                                out_wrote_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_addr_next = '0;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        pix_reg       <= pix_next;
        tgt_reg       <= tgt_next;
        tgt_zero_reg  <= tgt_zero_next;
        out_pix_reg   <= out_pix_next;
        out_wrote_reg <= out_wrote_next;
        out_addr_reg  <= out_addr_next;
    end

    assign m_tvalid      = out_valid_reg;
    assign pixel_value   = out_pix_reg;
    assign wrote         = out_wrote_reg;
    assign write_address = out_addr_reg;

endmodule

// ----- src/fire_effect_cell_engine_unit.sv -----
// Top level of the fire effect cell engine.
// Depends on fece_pkg, fece_front, fece_queue, fece_back and fece_ram.

// The engine keeps a byte-per-pixel fire frame of 640 x 240 cells plus one
// spare byte in a single on-chip RAM. Each input word names one cell and one
// action: read, clear, seed a bottom-row cell, propagate a cell one row up
// with random spread and decay, or jitter a bottom-row cell; every word gives
// exactly one result word. The frame RAM is not initialized by reset: clear
// and seed every cell before reading or propagating it. The back end handles
// one word at a time in a read-modify-write of the frame RAM (issue read, take
// read data, update and write); the front end classifies words and parks up to
// two in a queue, so input words are still taken while a result waits on the
// output register, until the queue is full.
module fire_effect_cell_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // col[9:0], row[17:10], offset_rand[19:18],
                                   // decay_rand[20], seed_rand[26:21],
                                   // jitter_rand[28:27], zero fill [31:29]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_value[7:0], write_address[25:8],
                                   // zero fill [31:26]
    output logic        m_tuser    // wrote[0]
);

    logic                        q_full;
    logic                        q_push;
    fece_pkg::cmd_t              q_in;
    logic                        q_pop;
    logic                        q_valid;
    fece_pkg::cmd_t              q_head;
    logic [fece_pkg::PIX_W-1:0]  pixel_value;
    logic [fece_pkg::ADDR_W-1:0] write_address;

    // Classify the word and form its cell address
    fece_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .action      (s_tuser),
        .col         (s_tdata[9:0]),
        .row         (s_tdata[17:10]),
        .offset_rand (s_tdata[19:18]),
        .decay_rand  (s_tdata[20]),
        .seed_rand   (s_tdata[26:21]),
        .jitter_rand (s_tdata[28:27]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_in)
    );

    // Hold classified commands until the back end is free
    fece_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // Carry out the read-modify-write and register the result
    fece_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_valid),
        .cmd           (q_head),
        .cmd_pop       (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .pixel_value   (pixel_value),
        .wrote         (m_tuser),
        .write_address (write_address)
    );

    assign m_tdata = {6'b0, write_address, pixel_value};

endmodule

// ----- tb/tb_fire_effect_cell_engine_unit.sv -----
// Self-checking testbench for fire_effect_cell_engine_unit: a queue-fed stream driver,
// a result monitor and a frame-image predictor that works out every result word.
// Depends on fece_pkg and the RTL under src/.
module tb_fire_effect_cell_engine_unit;
    import fece_pkg::*;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned USEFUL_TARGET = 1450;
    localparam int unsigned BOTTOM_ROW    = GRID_ROWS - 1;
    localparam logic [2:0]  ACT_LAST_CODE = 3'd7;

    typedef struct packed {
        logic [2:0]       action;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [1:0]       offs;
        logic             decay;
        logic [5:0]       seed;
        logic [1:0]       jit;
    } cell_cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic              wrote;
        logic [ADDR_W-1:0] addr;
    } cell_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // col[9:0], row[17:10], offset_rand[19:18],
                                   // decay_rand[20], seed_rand[26:21], jitter_rand[28:27]
    logic [2:0]  s_tuser  = '0;    // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // pixel_value[7:0], write_address[25:8]
    logic        m_tuser;          // wrote[0]

    cell_cmd_t    cell_cmd_q[$];       // words waiting for the driver
    cell_result_t pixel_expect_q[$];   // predicted result words, oldest first
    cell_cmd_t    held_cmd = '0;       // word currently offered on the input side

    // Predictor image of the frame store
    logic [PIX_W-1:0] frame_img[int unsigned];

    // Generator bookkeeping: cells known to be written once the queued words run
    bit          written_map[int unsigned];
    int unsigned written_list[$];

    int unsigned useful_items = 0;
    int unsigned words_in     = 0;
    int unsigned stall_cycles = 0;
    int unsigned fail_count   = 0;

    fire_effect_cell_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic logic [PIX_W-1:0] pixel_at(input int unsigned addr);
        return frame_img.exists(addr) ? frame_img[addr] : '0;
    endfunction

    // Work out the result word of one accepted command and update the frame image
    function automatic cell_result_t predict_cell_result(input cell_cmd_t c);
        cell_result_t     r;
        int unsigned      cell_addr;
        int unsigned      bottom_addr;
        int unsigned      target;
        logic [PIX_W-1:0] v;
        r           = '0;
        cell_addr   = c.row * GRID_COLS + c.col;
        bottom_addr = BOTTOM_ROW * GRID_COLS + c.col;
        // Drop unused codes and out-of-frame cells; seed and jitter ignore the row
        if (c.action > ACT_JITTER || c.col >= GRID_COLS)
            return r;
        if (c.action != ACT_SEED && c.action != ACT_JITTER && c.row >= GRID_ROWS)
            return r;
        case (c.action)
            ACT_READ:
            begin
                r = '{pixel: pixel_at(cell_addr), wrote: 1'b0, addr: cell_addr[ADDR_W-1:0]};
            end
            ACT_CLEAR:
            begin
                frame_img[cell_addr] = '0;
                r = '{pixel: '0, wrote: 1'b1, addr: cell_addr[ADDR_W-1:0]};
            end
            ACT_SEED:
            begin
                v = {c.seed, 2'b00};
                frame_img[bottom_addr] = v;
                r = '{pixel: v, wrote: 1'b1, addr: bottom_addr[ADDR_W-1:0]};
            end
            ACT_PROP:
            begin
                v = pixel_at(cell_addr);
                if (v > CLAMP_MAX)
                    v = CLAMP_MAX;
                r = '{pixel: v, wrote: 1'b0, addr: cell_addr[ADDR_W-1:0]};
                // Row zero, a cold cell and a target left of address zero write nothing
                if (c.row != 0 && v != 0)
                begin
                    target = (c.row - 1) * GRID_COLS + c.col + c.offs;
                    if (target != 0)
                    begin
                        target = target - 1;
                        v = c.decay ? v - STEP : v;
                        frame_img[target] = v;
                        r = '{pixel: v, wrote: 1'b1, addr: target[ADDR_W-1:0]};
                    end
                end
            end
            default:
            begin
                v = pixel_at(bottom_addr);
                r = '{pixel: v, wrote: 1'b0, addr: bottom_addr[ADDR_W-1:0]};
                if (c.jit != JITTER_NONE && v < JITTER_HIGH && v > JITTER_LOW)
                begin
                    v = v + {c.jit, 2'b00} - STEP;
                    frame_img[bottom_addr] = v;
                    r = '{pixel: v, wrote: 1'b1, addr: bottom_addr[ADDR_W-1:0]};
                end
            end
        endcase
        return r;
    endfunction

    // Both sides idle about one cycle in ten, except in a calm window of input words
    function automatic bit take_break();
        if (words_in >= 500 && words_in < 800)
            return 1'b0;
        return $urandom_range(0, 99) < 10;
    endfunction

    task automatic mark(input int unsigned addr);
        if (!written_map.exists(addr))
        begin
            written_map[addr] = 1'b1;
            written_list.push_back(addr);
        end
    endtask

    // Queue one command; track cells that it is sure to write
    task automatic send(input logic [2:0] act, input int col, input int row,
                        input int offs, input int decay, input int seed, input int jit);
        cell_cmd_t c;
        bit        dropped;
        c = '{action: act, col: col[COL_W-1:0], row: row[ROW_W-1:0], offs: offs[1:0],
              decay: decay[0], seed: seed[5:0], jit: jit[1:0]};
        dropped = act > ACT_JITTER || col >= GRID_COLS ||
                  (row >= GRID_ROWS && act != ACT_SEED && act != ACT_JITTER);
        if (!dropped)
        begin
            useful_items++;
            if (act == ACT_CLEAR)
                mark(row * GRID_COLS + col);
            else if (act == ACT_SEED)
                mark(BOTTOM_ROW * GRID_COLS + col);
        end
        cell_cmd_q.push_back(c);
    endtask

    task automatic send_any(input logic [2:0] act, input int col, input int row);
        send(act, col, row, $urandom_range(0, 3), $urandom_range(0, 1),
             $urandom_range(0, 63), $urandom_range(0, 3));
    endtask

    // Driver: hold the offered word until taken, then load the next pending one
    always @(posedge clk)
    begin : word_driver
        cell_cmd_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pixel_expect_q.push_back(predict_cell_result(held_cmd));
                words_in <= words_in + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cell_cmd_q.size() != 0 && !take_break())
                begin
                    nxt = cell_cmd_q.pop_front();
                    held_cmd <= nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, nxt.jit, nxt.seed, nxt.decay, nxt.offs,
                                 nxt.row, nxt.col};
                    s_tuser  <= nxt.action;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= !take_break();
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        cell_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_expect_q.size() == 0)
            begin
                $error("result word with no prediction waiting");
                fail_count++;
            end
            else
            begin
                want = pixel_expect_q.pop_front();
                if (m_tdata[7:0] !== want.pixel)
                begin
                    $error("pixel_value: expected %0d, got %0d", want.pixel, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tuser !== want.wrote)
                begin
                    $error("wrote: expected %0d, got %0d", want.wrote, m_tuser);
                    fail_count++;
                end
                if (m_tdata[25:8] !== want.addr)
                begin
                    $error("write_address: expected %0d, got %0d", want.addr, m_tdata[25:8]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int          c;
        int          r;
        int          base;
        int          rows;
        int          top;
        int          k;
        int          seed;
        int unsigned a;
        bit          chain_done;
        logic [2:0]  act;
        chain_done = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: corners, seed and jitter thresholds, propagate edge cases, noise
        send_any(ACT_CLEAR, 0, 0);
        send_any(ACT_CLEAR, GRID_COLS - 1, BOTTOM_ROW);
        send_any(ACT_READ, 0, 0);
        send(ACT_SEED, GRID_COLS - 1, 255, 0, 0, 63, 0);        // 252, top of range
        send(ACT_JITTER, GRID_COLS - 1, 0, 0, 0, 0, 0);         // 252 is not jittered
        send(ACT_SEED, 0, 0, 0, 0, 1, 0);                       // 4
        send(ACT_JITTER, 0, 0, 0, 0, 0, 2);                     // 4 is not jittered
        send(ACT_SEED, 1, 128, 0, 0, 2, 0);                     // 8
        send(ACT_JITTER, 1, 0, 0, 0, 0, 0);                     // down to 4
        send(ACT_JITTER, 1, 0, 0, 0, 0, JITTER_NONE);
        send(ACT_SEED, 2, 0, 0, 0, 62, 0);                      // 248
        send(ACT_JITTER, 2, 0, 0, 0, 0, 2);                     // up to 252
        // Spread right past the last column lands on the next row's second cell
        send(ACT_PROP, GRID_COLS - 1, BOTTOM_ROW, 3, 1, 0, 0);
        // Spread left of column zero lands on the previous row's end
        send(ACT_PROP, 0, BOTTOM_ROW, 0, 0, 0, 0);
        mark((BOTTOM_ROW - 1) * GRID_COLS - 1);
        send_any(ACT_READ, GRID_COLS - 1, BOTTOM_ROW - 2);
        send_any(ACT_CLEAR, 5, 0);
        send_any(ACT_PROP, 5, 0);                               // row zero
        send_any(ACT_CLEAR, 0, 1);
        send(ACT_PROP, 0, 1, 0, 1, 0, 0);                       // cold cell
        send_any(ACT_READ, 1, BOTTOM_ROW);
        send_any(ACT_JITTER + 3'd1, 0, 0);
        send_any(ACT_LAST_CODE, 1023, 255);
        send_any(ACT_READ, 1023, 0);
        send_any(ACT_CLEAR, 0, 255);
        send_any(ACT_PROP, GRID_COLS - 1, GRID_ROWS);

        // Hold off until every predicted word has come back
        while (cell_cmd_q.size() != 0 || s_tvalid || pixel_expect_q.size() != 0)
            @(posedge clk);

        while (useful_items < USEFUL_TARGET)
        begin
            if (!chain_done && useful_items > 700)
            begin
                // Drain, then carry one hot cell from the bottom row up to row zero
                while (cell_cmd_q.size() != 0 || s_tvalid || pixel_expect_q.size() != 0)
                    @(posedge clk);
                send(ACT_SEED, 0, $urandom_range(0, 255), 0, 0, 63, $urandom_range(0, 3));
                for (r = BOTTOM_ROW; r >= 1; r--)
                begin
                    send(ACT_PROP, 0, r, 1, 0, $urandom_range(0, 63), $urandom_range(0, 3));
                    mark((r - 1) * GRID_COLS);
                end
                send(ACT_PROP, 0, 1, 0, $urandom_range(0, 1), 0, 0);    // negative target
                send_any(ACT_PROP, 0, 0);                               // hot row zero
                send_any(ACT_READ, 0, 0);
                chain_done = 1'b1;
                continue;
            end
            k = $urandom_range(0, 99);
            if (k < 55 || written_list.size() == 0)
            begin
                // Burn a small patch: clear, seed, jitter, propagate upward, read back
                k = $urandom_range(0, 9);
                base = (k == 0) ? 0 : (k == 1) ? GRID_COLS - 4 :
                       $urandom_range(0, GRID_COLS - 4);
                rows = $urandom_range(1, 3);
                top  = BOTTOM_ROW - rows;
                for (r = top; r <= BOTTOM_ROW; r++)
                    for (c = base - 1; c <= base + 5; c++)
                        if (c >= 0 && c < GRID_COLS &&
                            !written_map.exists(r * GRID_COLS + c))
                            send_any(ACT_CLEAR, c, r);
                for (c = base; c <= base + 3; c++)
                begin
                    k = $urandom_range(0, 9);
                    seed = (k == 0) ? 0 : (k == 1) ? 63 : (k == 2) ? 1 : $urandom_range(0, 63);
                    send(ACT_SEED, c, $urandom_range(0, 255), $urandom_range(0, 3),
                         $urandom_range(0, 1), seed, $urandom_range(0, 3));
                end
                for (c = base; c <= base + 3; c++)
                    if ($urandom_range(0, 1))
                        send_any(ACT_JITTER, c, $urandom_range(0, 255));
                for (r = BOTTOM_ROW; r > top; r--)
                    for (c = base; c <= base + 3; c++)
                        send_any(ACT_PROP, c, r);
                repeat (3)
                begin
                    c = base - 1 + $urandom_range(0, 6);
                    if (c < 0)
                        c = 0;
                    if (c >= GRID_COLS)
                        c = GRID_COLS - 1;
                    send_any(ACT_READ, c, top + $urandom_range(0, rows));
                end
            end
            else if (k < 88)
            begin
                // Any operation on a cell already written
                a = written_list[$urandom_range(0, written_list.size() - 1)];
                c = a % GRID_COLS;
                r = a / GRID_COLS;
                case ($urandom_range(0, 4))
                    0: send_any(ACT_READ, c, r);
                    1: send_any(ACT_CLEAR, c, r);
                    2: send_any(ACT_SEED, c, $urandom_range(0, 255));
                    3: send_any(ACT_PROP, c, r);
                    default:
                    begin
                        if (written_map.exists(BOTTOM_ROW * GRID_COLS + c))
                            send_any(ACT_JITTER, c, $urandom_range(0, 255));
                        else
                            send_any(ACT_SEED, c, $urandom_range(0, 255));
                    end
                endcase
            end
            else
            begin
                // Noise: unused codes, columns past the frame, rows past the frame
                case ($urandom_range(0, 2))
                    0: send_any(3'($urandom_range(ACT_JITTER + 3'd1, ACT_LAST_CODE)),
                                $urandom_range(0, 1023), $urandom_range(0, 255));
                    1: send_any(3'($urandom_range(ACT_READ, ACT_JITTER)),
                                $urandom_range(GRID_COLS, 1023), $urandom_range(0, 255));
                    default:
                    begin
                        k = $urandom_range(0, 2);
                        act = (k == 0) ? ACT_READ : (k == 1) ? ACT_CLEAR : ACT_PROP;
                        send_any(act, $urandom_range(0, GRID_COLS - 1),
                                 $urandom_range(GRID_ROWS, 255));
                    end
                endcase
            end
        end

        // Let the stream drain, then allow for the pipeline latency
        while (cell_cmd_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- fire_effect_cell_engine_unit.f -----
src/fece_pkg.sv
src/fece_ram.sv
src/fece_front.sv
src/fece_queue.sv
src/fece_back.sv
src/fire_effect_cell_engine_unit.sv
tb/tb_fire_effect_cell_engine_unit.sv
